// ===== sv/aefd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aefd_pkg
// Shared types and constants of the audio frame deframer: result record,
// result kinds, frame status codes and parameter defaults.
// ----------------------------------------------------------------------------
package aefd_pkg;

  // Parameter defaults
  localparam int DefMaxChannels     = 64;
  localparam int DefMinFrameBytes   = 60;
  localparam int DefCounterOffset   = 14;
  localparam int DefStreamOffset    = 15;
  localparam int DefAudioBaseOffset = 16;
  localparam int DefMaxFrameBytes   = 2047;

  // Result queue depth; input is held off unless two entries are free
  localparam int QueueDepth = 4;

  // Width used to compare frame length against the minimum length
  localparam int CmpW = 17;

  // Largest limit the 7-bit channel register can express
  localparam int LimitCeil = 127;

  localparam logic [6:0] ChannelLimitReset = 7'd64;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_NOT_BCAST = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PHASE_HI  = 2'd0,
    PHASE_MID = 2'd1,
    PHASE_LO  = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t              result_kind;
    logic signed [23:0] sample_value;
    logic [5:0]         sample_channel;
    logic [47:0]        dst_address;
    logic [47:0]        src_address;
    logic [15:0]        ether_type;
    logic [4:0]         sequence_counter;
    logic [7:0]         stream_kind;
    logic [6:0]         channel_total;
    status_t            frame_status;
    logic               run_last;
  } result_t;

  // Up to two results caused by one input beat; second implies first
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } result_pair_t;

endpackage
`default_nettype wire

// ===== sv/aefd_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aefd_parse
// Per-frame parser: tracks byte position, captures header fields, assembles
// 24-bit samples and builds the sample and end-of-frame summary results.
// ----------------------------------------------------------------------------
module aefd_parse
  import aefd_pkg::*;
#(
  parameter int CHANNEL_CEILING    = DefMaxChannels,
  parameter int MIN_FRAME_BYTES    = DefMinFrameBytes,
  parameter int COUNTER_OFFSET     = DefCounterOffset,
  parameter int STREAM_TYPE_OFFSET = DefStreamOffset,
  parameter int AUDIO_BASE_OFFSET  = DefAudioBaseOffset,
  parameter int MAX_FRAME_BYTES    = DefMaxFrameBytes
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  wire logic [7:0]   in_byte,
  input  wire logic         frame_end,
  input  wire logic [6:0]   channel_limit,
  output result_pair_t      push
);

  localparam int PW     = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CapLim = (CHANNEL_CEILING > LimitCeil) ? LimitCeil : CHANNEL_CEILING;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [47:0]   dst_shift, dst_shift_next;
  logic [47:0]   src_shift, src_shift_next;
  logic [15:0]   type_shift, type_shift_next;
  logic [4:0]    counter_hold, counter_hold_next;
  logic [7:0]    stream_hold, stream_hold_next;
  logic [15:0]   sample_partial, sample_partial_next;
  phase_t        sample_phase, sample_phase_next;
  logic [6:0]    channels_seen, channels_seen_next;
  logic          broadcast_ok, broadcast_ok_next;

  logic [6:0]    limit;
  logic          emit;
  logic [23:0]   raw;
  status_t       status;
  result_t       sample_res;
  result_t       summary_res;

  // Decode one byte against the frame layout
  always_comb begin
    byte_position_next  = byte_position;
    dst_shift_next      = dst_shift;
    src_shift_next      = src_shift;
    type_shift_next     = type_shift;
    counter_hold_next   = counter_hold;
    stream_hold_next    = stream_hold;
    sample_partial_next = sample_partial;
    sample_phase_next   = sample_phase;
    channels_seen_next  = channels_seen;
    broadcast_ok_next   = broadcast_ok;
    emit                = 1'b0;
    raw                 = {sample_partial, in_byte};

    limit = (channel_limit < 7'(CapLim)) ? channel_limit : 7'(CapLim);

    // Header shift registers
    if (byte_position < PW'(6)) begin
      dst_shift_next = {dst_shift[39:0], in_byte};
      if (in_byte != 8'hff) begin
        broadcast_ok_next = 1'b0;
      end
    end else if (byte_position < PW'(12)) begin
      src_shift_next = {src_shift[39:0], in_byte};
    end else if (byte_position < PW'(14)) begin
      type_shift_next = {type_shift[7:0], in_byte};
    end
    if (byte_position == PW'(COUNTER_OFFSET)) begin
      counter_hold_next = in_byte[4:0];
    end
    if (byte_position == PW'(STREAM_TYPE_OFFSET)) begin
      stream_hold_next = in_byte;
    end

    // Sample assembly, most significant byte first
    if (byte_position >= PW'(AUDIO_BASE_OFFSET)) begin
      case (sample_phase)
        PHASE_HI: begin
          sample_partial_next = {8'd0, in_byte};
          sample_phase_next   = PHASE_MID;
        end
        PHASE_MID: begin
          sample_partial_next = {sample_partial[7:0], in_byte};
          sample_phase_next   = PHASE_LO;
        end
        default: begin
          sample_partial_next = 16'd0;
          sample_phase_next   = PHASE_HI;
          if (broadcast_ok_next && (channels_seen < limit)) begin
            emit               = 1'b1;
            channels_seen_next = channels_seen + 7'd1;
          end
        end
      endcase
    end

    // Saturating position count
    if (byte_position != PW'(MAX_FRAME_BYTES)) begin
      byte_position_next = byte_position + PW'(1);
    end

    // Status: too short wins over not broadcast
    if (CmpW'(byte_position_next) < CmpW'(MIN_FRAME_BYTES)) begin
      status = STATUS_SHORT;
    end else if (!broadcast_ok_next) begin
      status = STATUS_NOT_BCAST;
    end else begin
      status = STATUS_OK;
    end

    sample_res                = '0;
    sample_res.result_kind    = KIND_SAMPLE;
    sample_res.sample_value   = raw;
    sample_res.sample_channel = channels_seen[5:0];

    summary_res                  = '0;
    summary_res.result_kind      = KIND_SUMMARY;
    summary_res.dst_address      = dst_shift_next;
    summary_res.src_address      = src_shift_next;
    summary_res.ether_type       = type_shift_next;
    summary_res.sequence_counter = counter_hold_next;
    summary_res.stream_kind      = stream_hold_next;
    summary_res.channel_total    = channels_seen_next;
    summary_res.frame_status     = status;
    summary_res.run_last         = 1'b1;

    // Sample goes ahead of the summary on the same beat
    push.v0 = fire && (emit || frame_end);
    push.v1 = fire && emit && frame_end;
    push.r0 = emit ? sample_res : summary_res;
    push.r1 = summary_res;
  end

  // Advance frame state on each accepted beat; clear it at frame end
  always_ff @(posedge clk) begin
    if (rst || (fire && frame_end)) begin
      byte_position  <= '0;
      dst_shift      <= '0;
      src_shift      <= '0;
      type_shift     <= '0;
      counter_hold   <= '0;
      stream_hold    <= '0;
      sample_partial <= '0;
      sample_phase   <= PHASE_HI;
      channels_seen  <= '0;
      broadcast_ok   <= 1'b1;
    end else if (fire) begin
      byte_position  <= byte_position_next;
      dst_shift      <= dst_shift_next;
      src_shift      <= src_shift_next;
      type_shift     <= type_shift_next;
      counter_hold   <= counter_hold_next;
      stream_hold    <= stream_hold_next;
      sample_partial <= sample_partial_next;
      sample_phase   <= sample_phase_next;
      channels_seen  <= channels_seen_next;
      broadcast_ok   <= broadcast_ok_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/aefd_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aefd_outq
// Small result queue: takes up to two results per cycle, hands out one per
// cycle while it is popped, and reports when two entries are free.
// ----------------------------------------------------------------------------
module aefd_outq
  import aefd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire result_pair_t  push,
  input  wire logic          pop,
  output result_t            head,
  output logic               not_empty,
  output logic               room2
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  result_t         entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr, wr_ptr_next;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic [CntW-1:0] n_push;

  assign n_push    = CntW'(push.v0) + CntW'(push.v1);
  assign not_empty = (count != '0);
  assign room2     = (count <= CntW'(QueueDepth - 2));
  assign head      = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + PtrW'(n_push);
    count_next  = count + n_push - CntW'(pop);
  end

  // Write payload entries
  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      entries[wr_ptr + PtrW'(1)] <= push.r1;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/audio_ethernet_frame_deframer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// audio_ethernet_frame_deframer_unit
// Byte-wide Ethernet audio deframer with per-frame summary.
// ----------------------------------------------------------------------------
// Takes one frame byte per beat, one byte every clock while in_ready is high.
// Each byte is decoded in the cycle it is accepted; its results (a sample, a
// summary, or a sample then a summary on the final byte) enter a four-entry
// result queue and leave it one per cycle while out_ready is high. in_ready
// drops only when fewer than two queue entries are free, so with the output
// draining every cycle the input never stalls. Samples are passed only for
// broadcast frames; a frame whose summary status is not ok should have its
// samples discarded. channel_limit may be written at any time the block idles.
// ----------------------------------------------------------------------------
module audio_ethernet_frame_deframer_unit
  import aefd_pkg::*;
#(
  parameter int CHANNEL_CEILING    = DefMaxChannels,
  parameter int MIN_FRAME_BYTES    = DefMinFrameBytes,
  parameter int COUNTER_OFFSET     = DefCounterOffset,
  parameter int STREAM_TYPE_OFFSET = DefStreamOffset,
  parameter int AUDIO_BASE_OFFSET  = DefAudioBaseOffset,
  parameter int MAX_FRAME_BYTES    = DefMaxFrameBytes
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [6:0]         channel_limit,
  // byte input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               frame_end,
  // result output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    result_kind,
  output logic signed [23:0]      sample_value,
  output logic [5:0]              sample_channel,
  output logic [47:0]             dst_address,
  output logic [47:0]             src_address,
  output logic [15:0]             ether_type,
  output logic [4:0]              sequence_counter,
  output logic [7:0]              stream_kind,
  output logic [6:0]              channel_total,
  output logic [1:0]              frame_status,
  output logic                    run_last
);

  logic         limit_reg;
  logic [6:0]   chan_limit;
  logic         in_fire;
  logic         room2;
  result_pair_t push;
  result_t      head;

  assign cfg_ready = 1'b1;
  assign limit_reg = cfg_valid && cfg_ready;
  assign in_ready  = room2;
  assign in_fire   = in_valid && in_ready;

  // Hold the channel limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_limit <= ChannelLimitReset;
    end else if (limit_reg) begin
      chan_limit <= channel_limit;
    end
  end

  aefd_parse #(
    .CHANNEL_CEILING    (CHANNEL_CEILING),
    .MIN_FRAME_BYTES    (MIN_FRAME_BYTES),
    .COUNTER_OFFSET     (COUNTER_OFFSET),
    .STREAM_TYPE_OFFSET (STREAM_TYPE_OFFSET),
    .AUDIO_BASE_OFFSET  (AUDIO_BASE_OFFSET),
    .MAX_FRAME_BYTES    (MAX_FRAME_BYTES)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .fire          (in_fire),
    .in_byte       (in_byte),
    .frame_end     (frame_end),
    .channel_limit (chan_limit),
    .push          (push)
  );

  aefd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_valid && out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  // Unpack the head result onto the output ports
  assign result_kind      = head.result_kind;
  assign sample_value     = head.sample_value;
  assign sample_channel   = head.sample_channel;
  assign dst_address      = head.dst_address;
  assign src_address      = head.src_address;
  assign ether_type       = head.ether_type;
  assign sequence_counter = head.sequence_counter;
  assign stream_kind      = head.stream_kind;
  assign channel_total    = head.channel_total;
  assign frame_status     = head.frame_status;
  assign run_last         = head.run_last;

endmodule
`default_nettype wire

// ===== tb/sv/tb_audio_ethernet_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_ethernet_frame_deframer_unit
// Self-checking bench for the byte-wide audio frame deframer.
// ----------------------------------------------------------------------------
// Feeds frame bytes through the valid/ready input while a local decoder
// predicts the samples and frame summaries that each accepted beat causes.
// The output side stalls at random and every result beat is compared field
// by field with the oldest prediction. A short directed table comes first.
// It is followed by random frames under several channel limits: broadcast,
// almost broadcast and unicast destinations, short and long lengths, and
// trailing partial samples.
// ----------------------------------------------------------------------------
module tb_audio_ethernet_frame_deframer_unit;
  import aefd_pkg::*;

  localparam int CycleLimit   = 2000000;
  localparam int RandomBytes  = 1050;
  localparam int PhaseCount   = 6;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 20;
  localparam int DrainLimit   = 5000;
  localparam int ShortLen     = 22;

  // Broadcast frame that ends on a complete sample: both sample extremes
  localparam logic [ShortLen*8-1:0] SHORT_FRAME = {
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80,
    8'h86, 8'hdd,
    8'hff, 8'h00,
    8'h80, 8'h00, 8'h00,
    8'h7f, 8'hff, 8'hff
  };

  typedef enum logic [1:0] {
    FRM_BCAST,
    FRM_NEAR_BCAST,
    FRM_UNICAST
  } frame_style_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  channel_limit = ChannelLimitReset;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        frame_end = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               result_kind;
  logic signed [23:0] sample_value;
  logic [5:0]         sample_channel;
  logic [47:0]        dst_address;
  logic [47:0]        src_address;
  logic [15:0]        ether_type;
  logic [4:0]         sequence_counter;
  logic [7:0]         stream_kind;
  logic [6:0]         channel_total;
  logic [1:0]         frame_status;
  logic               run_last;

  // Decoder state mirrored from the block
  logic [6:0]  chan_cap;
  logic [10:0] frame_pos;
  logic [47:0] dst_acc;
  logic [47:0] src_acc;
  logic [15:0] type_acc;
  logic [4:0]  seq_hold;
  logic [7:0]  kind_hold;
  logic [15:0] partial_acc;
  phase_t      phase_now;
  logic [6:0]  emitted;
  logic        is_bcast;

  result_t   awaited[$];
  stim_row_t directed_rows[ShortLen + 2];
  int        errors = 0;

  audio_ethernet_frame_deframer_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .channel_limit    (channel_limit),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .frame_end        (frame_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .sample_value     (sample_value),
    .sample_channel   (sample_channel),
    .dst_address      (dst_address),
    .src_address      (src_address),
    .ether_type       (ether_type),
    .sequence_counter (sequence_counter),
    .stream_kind      (stream_kind),
    .channel_total    (channel_total),
    .frame_status     (frame_status),
    .run_last         (run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Timeout guard
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("** audio_ethernet_frame_deframer_unit: FAILED **");
    $finish;
  end

  // Return per-frame decoder state to its reset values
  function automatic void clear_frame();
    frame_pos   = '0;
    dst_acc     = '0;
    src_acc     = '0;
    type_acc    = '0;
    seq_hold    = '0;
    kind_hold   = '0;
    partial_acc = '0;
    phase_now   = PHASE_HI;
    emitted     = '0;
    is_bcast    = 1'b1;
  endfunction

  // Decode one byte; return how many results it causes (0, 1 or 2)
  function automatic int deframe_byte(input logic [7:0] b, input logic last,
                                      output result_t first, output result_t second);
    result_t     r;
    logic [23:0] raw;
    int          eff;
    int          n;
    n      = 0;
    first  = '0;
    second = '0;
    eff    = (chan_cap < DefMaxChannels) ? chan_cap : DefMaxChannels;

    // Header capture
    if (frame_pos < 6) begin
      dst_acc = {dst_acc[39:0], b};
      if (b != 8'hff) is_bcast = 1'b0;
    end else if (frame_pos < 12) begin
      src_acc = {src_acc[39:0], b};
    end else if (frame_pos < 14) begin
      type_acc = {type_acc[7:0], b};
    end
    if (frame_pos == DefCounterOffset) seq_hold = b[4:0];
    if (frame_pos == DefStreamOffset) kind_hold = b;

    // Sample assembly, most significant byte first
    if (frame_pos >= DefAudioBaseOffset) begin
      case (phase_now)
        PHASE_HI: begin
          partial_acc = {8'h00, b};
          phase_now   = PHASE_MID;
        end
        PHASE_MID: begin
          partial_acc = {partial_acc[7:0], b};
          phase_now   = PHASE_LO;
        end
        default: begin
          raw         = {partial_acc, b};
          phase_now   = PHASE_HI;
          partial_acc = '0;
          if (is_bcast && emitted < eff) begin
            r                = '0;
            r.result_kind    = KIND_SAMPLE;
            r.sample_value   = raw;
            r.sample_channel = emitted[5:0];
            emitted          = emitted + 7'd1;
            first            = r;
            n                = 1;
          end
        end
      endcase
    end

    // Saturate the position count
    if (frame_pos < DefMaxFrameBytes) frame_pos = frame_pos + 11'd1;

    // Frame summary; too short wins over not broadcast
    if (last) begin
      r                  = '0;
      r.result_kind      = KIND_SUMMARY;
      r.dst_address      = dst_acc;
      r.src_address      = src_acc;
      r.ether_type       = type_acc;
      r.sequence_counter = seq_hold;
      r.stream_kind      = kind_hold;
      r.channel_total    = emitted;
      if (frame_pos < DefMinFrameBytes) r.frame_status = STATUS_SHORT;
      else if (!is_bcast) r.frame_status = STATUS_NOT_BCAST;
      else r.frame_status = STATUS_OK;
      r.run_last = 1'b1;
      if (n == 0) first = r;
      else second = r;
      n++;
      clear_frame();
    end
    return n;
  endfunction

  function automatic result_t short_summary(input logic [47:0] dst);
    result_t r;
    r               = '0;
    r.result_kind   = KIND_SUMMARY;
    r.dst_address   = dst;
    r.frame_status  = STATUS_SHORT;
    r.run_last      = 1'b1;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one byte beat and hold it until accepted; log its predictions
  task automatic present_byte(input logic [7:0] b, input logic last,
                              input logic typed, input result_t want);
    result_t first;
    result_t second;
    int      n;
    in_valid  <= 1'b1;
    in_byte   <= b;
    frame_end <= last;
    do @(posedge clk); while (!in_ready);
    n = deframe_byte(b, last, first, second);
    if (typed) begin
      awaited.push_back(want);
    end else begin
      if (n > 0) awaited.push_back(first);
      if (n > 1) awaited.push_back(second);
    end
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int len, input frame_style_t style, input bit burst);
    int         spoil;
    logic [7:0] b;
    spoil = $urandom_range(0, 5);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i < 6) begin
        case (style)
          FRM_BCAST:      b = 8'hff;
          FRM_NEAR_BCAST: b = (i == spoil) ? 8'($urandom_range(0, 254)) : 8'hff;
          default:        ;
        endcase
      end
      present_byte(b, i == len - 1, 1'b0, '0);
      if (!burst) idle(pick_gap());
    end
  endtask

  // Hold input idle until every prediction has been matched
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] value);
    cfg_valid     <= 1'b1;
    channel_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chan_cap = value;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Output stalls: free-running stretches, short stalls, long stalls
  initial begin
    int r;
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else if (r < 8) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result beat: result_kind %0d", result_kind);
        errors++;
      end else begin
        want = awaited.pop_front();
        compare_field("result_kind", want.result_kind, result_kind);
        compare_field("sample_value", want.sample_value, sample_value);
        compare_field("sample_channel", want.sample_channel, sample_channel);
        compare_field("dst_address", want.dst_address, dst_address);
        compare_field("src_address", want.src_address, src_address);
        compare_field("ether_type", want.ether_type, ether_type);
        compare_field("sequence_counter", want.sequence_counter, sequence_counter);
        compare_field("stream_kind", want.stream_kind, stream_kind);
        compare_field("channel_total", want.channel_total, channel_total);
        compare_field("frame_status", want.frame_status, frame_status);
        compare_field("run_last", want.run_last, run_last);
      end
    end
  end

  initial begin
    logic [6:0]   limits[PhaseCount];
    frame_style_t style;
    int           used;
    int           len;
    int           r;
    int           budget;

    chan_cap = ChannelLimitReset;
    clear_frame();

    // One-byte frames right after reset: too short, broadcast or not
    directed_rows[0] = '{data: 8'hff, last: 1'b1, typed: 1'b1, want: short_summary(48'hff)};
    directed_rows[1] = '{data: 8'h00, last: 1'b1, typed: 1'b1, want: short_summary(48'h0)};
    for (int i = 0; i < ShortLen; i++) begin
      directed_rows[i + 2] = '{data: SHORT_FRAME[(ShortLen - 1 - i)*8 +: 8],
                               last: (i == ShortLen - 1), typed: 1'b0, want: '0};
    end

    limits = '{7'd127, 7'd0, 7'd1, 7'd2, 7'($urandom_range(3, 63)), 7'd64};
    budget = RandomBytes / PhaseCount;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i]) begin
      present_byte(directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);
      idle(pick_gap());
    end

    // Random frames under each channel limit
    foreach (limits[p]) begin
      settle();
      write_limit(limits[p]);
      used = 0;
      while (used < budget) begin
        r = $urandom_range(0, 99);
        if (r < 45) len = $urandom_range(60, 100);
        else if (r < 60) len = $urandom_range(196, 215);
        else if (r < 80) len = $urandom_range(16, 59);
        else len = $urandom_range(1, 15);
        r = $urandom_range(0, 99);
        if (r < 65) style = FRM_BCAST;
        else if (r < 82) style = FRM_NEAR_BCAST;
        else style = FRM_UNICAST;
        send_frame(len, style, $urandom_range(0, 3) == 0);
        used += len;
      end
    end

    // Drain and look for stray beats
    in_valid <= 1'b0;
    for (int w = 0; w < DrainLimit && awaited.size() != 0; w++) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (awaited.size() != 0) begin
      $error("%0d expected results never arrived", awaited.size());
      errors++;
    end

    if (errors == 0) begin
      $display("** audio_ethernet_frame_deframer_unit: PASSED **");
    end else begin
      $display("** audio_ethernet_frame_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
